/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the loop-current scaler.
// Checks compile only when SYNTH is not defined; with SYNTH they expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_ALWAYS(lbl, clk_s, rst_s, expr) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (expr)) \
    else $error("assertion failed");

`define ASSERT_IMPLIES(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk_s, rst_s, expr)
`define ASSERT_IMPLIES(lbl, clk_s, rst_s, ante, cons)
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

/* rtl/clsod_pkg.sv */
// Types, codes and constants of the loop-current scaler with send-on-delta.
// No dependencies; the top level imports it.
package clsod_pkg;

  localparam int CHANNELS_DEF  = 4;
  localparam int PERIOD_MS_DEF = 1000;
  localparam int MAX_CH        = 4;

  // stored sample width: scaled values stay below 2^24 in magnitude
  localparam int VAL_W = 25;

  typedef enum logic [2:0] {
    REG_INPUT_MODE  = 3'd0,
    REG_SENSOR_KIND = 3'd1,
    REG_POINT_LOW   = 3'd2,
    REG_POINT_HIGH  = 3'd3,
    REG_SEND_CYCLE  = 3'd4,
    REG_ABS_THRESH  = 3'd5,
    REG_REL_PERCENT = 3'd6
  } cfg_reg_t;

  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_4_20 = 2'd1;
  localparam logic [1:0] MODE_0_20 = 2'd2;

  localparam logic [3:0] KIND_CURRENT  = 4'd0;
  localparam logic [3:0] KIND_HUMIDITY = 4'd2;
  localparam logic [3:0] KIND_PERCENT  = 4'd9;

  // reciprocals: floor(x/d) = (x * RECIP) >> SHIFT over the value range used
  localparam logic [19:0] RECIP10  = 20'd104858;     // shift 20, x < 2^16
  localparam logic [27:0] RECIP5   = 28'd214748365;  // shift 30, x < 2^27
  localparam logic [29:0] RECIP25  = 30'd687194768;  // shift 34, x < 2^29
  localparam logic [28:0] RECIP625 = 29'd439804652;  // shift 38, x < 2^28
  localparam logic [18:0] RECIP625_S = 19'd429497;   // shift 28, x < 2^18

  localparam logic [16:0] LOW_END_UA  = 17'd4000;
  localparam logic [VAL_W-1:0] REL_MIN_VALUE = VAL_W'(20);
  localparam logic [VAL_W-1:0] PCT_SAT_VALUE = VAL_W'(10019);
  localparam logic [7:0] REL_FIXED = 8'd100;

  // one channel's settings travel with the beat through the pipeline
  typedef struct packed {
    logic [1:0]         ch;
    logic               ready;
    logic [31:0]        now;
    logic [14:0]        cur;
    logic [1:0]         mode;
    logic [3:0]         kind;
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    logic [15:0]        cyc_s;
    logic [15:0]        athr;
    logic [7:0]         rel;
  } item_t;

endpackage

/* rtl/current_loop_scale_send_on_delta.sv */
// Top level of the loop-current scaler with send-on-delta.
// Depends on clsod_pkg and assert_macros.svh.

// The block serves its channels round-robin, one input beat per channel turn, and
// returns exactly one result beat per input beat, in order. It takes one beat per
// clock cycle while the output side is ready; each beat passes six pipeline stages
// and the output register. The scaling product, the divisions by 160 or 200, the
// relative-threshold limit and the percent byte are each computed in a stage of their
// own; all per-channel state is read and updated in the last stage only, so beats for
// the same channel may follow each other directly. When the output stalls the stages
// fill and keep taking beats until the pipeline is full. Configuration writes are
// always taken and must only be issued while the pipeline is empty; index 7 is
// ignored.
`include "assert_macros.svh"

module current_loop_scale_send_on_delta
  import clsod_pkg::*;
#(
  parameter int CHANNELS          = CHANNELS_DEF,
  parameter int PROCESS_PERIOD_MS = PERIOD_MS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] ready_req, [32:1] now_ms, [47:33] current_ua
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] channel, [2] sent, [29:3] value_centi, [37:30] percent_byte, [39:38] zero
  output logic [39:0] m_axis_tdata,
  // [0] is_percent
  output logic [0:0]  m_axis_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int STG_OUT = 6;
  localparam int NSTG    = STG_OUT + 1;
  localparam logic [1:0]  LAST_CH  = 2'(CHANNELS - 1);
  localparam logic [31:0] PERIOD32 = 32'(PROCESS_PERIOD_MS);

  // configuration
  logic [MAX_CH-1:0][1:0]  mode_cfg;
  logic [MAX_CH-1:0][3:0]  kind_cfg;
  logic [MAX_CH-1:0][15:0] lo_cfg;
  logic [MAX_CH-1:0][15:0] hi_cfg;
  logic [MAX_CH-1:0][15:0] cyc_cfg;
  logic [MAX_CH-1:0][15:0] athr_cfg;
  logic [MAX_CH-1:0][7:0]  rel_cfg;

  // flow control
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] vld_next;
  logic [NSTG-1:0] ld;
  logic [NSTG-1:0] take;

  logic [1:0] ptr;
  item_t      item_in;
  item_t      stg_item [STG_OUT];

  // per-channel state
  logic [31:0]             last_process_ms     [MAX_CH];
  logic [31:0]             last_send_ms        [MAX_CH];
  logic signed [VAL_W-1:0] last_sent_value     [MAX_CH];
  logic signed [VAL_W-1:0] last_computed_value [MAX_CH];
  logic [7:0]              last_percent        [MAX_CH];

  // stage 2
  logic signed [16:0] dx_c;
  logic signed [16:0] cm_c;
  logic signed [33:0] prod_c;
  logic [35:0]        c10_full;
  logic signed [31:0] s2_prod;
  logic [11:0]        s2_c10;
  // stage 3
  logic [31:0] amag;
  logic [31:0] sum1;
  logic [31:0] sum2;
  logic [54:0] q1_full;
  logic [58:0] q2_full;
  logic [23:0] s3_qmag;
  logic        s3_neg;
  logic [11:0] s3_c10;
  // stage 4
  logic signed [VAL_W-1:0] lo25;
  logic signed [VAL_W-1:0] base_c;
  logic signed [VAL_W-1:0] qs_c;
  logic signed [VAL_W-1:0] v_c;
  logic signed [VAL_W-1:0] s4_v;
  // stage 5
  logic [7:0]              relv;
  logic                    relok_c;
  logic [31:0]             x_c;
  logic [21:0]             y_c;
  logic [36:0]             pb_full;
  logic [7:0]              pb_c;
  logic signed [VAL_W-1:0] s5_v;
  logic [31:0]             s5_x;
  logic                    s5_relok;
  logic [7:0]              s5_pb;
  // stage 6
  logic [32:0]             xs_c;
  logic [57:0]             t_full;
  logic [18:0]             t_c;
  logic signed [VAL_W-1:0] s6_v;
  logic                    s6_relok;
  logic [25:0]             s6_tmin;
  logic [22:0]             s6_athr;
  logic [25:0]             s6_cyc;
  logic [7:0]              s6_pb;
  // last stage
  logic [1:0]              fin_ch;
  logic signed [27:0]      diff;
  logic signed [27:0]      athr28;
  logic signed [27:0]      tmin28;
  logic                    abs_hit;
  logic                    rel_hit;
  logic                    active;
  logic                    cyc_hit;
  logic                    fin_sample;
  logic                    fin_sent;
  logic signed [VAL_W-1:0] val_new;
  logic [7:0]              pb_cur;
  logic                    fin_pct;
  // output register
  logic [1:0]              out_ch;
  logic                    out_sent;
  logic signed [VAL_W-1:0] out_val;
  logic [7:0]              out_pb;
  logic                    out_pct;

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_cfg <= '0;
      kind_cfg <= '0;
      lo_cfg   <= '0;
      hi_cfg   <= '0;
      cyc_cfg  <= '0;
      athr_cfg <= '0;
      rel_cfg  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_INPUT_MODE:  mode_cfg <= cfg_data[7:0];
        REG_SENSOR_KIND: kind_cfg <= cfg_data[15:0];
        REG_POINT_LOW:   lo_cfg   <= cfg_data;
        REG_POINT_HIGH:  hi_cfg   <= cfg_data;
        REG_SEND_CYCLE:  cyc_cfg  <= cfg_data;
        REG_ABS_THRESH:  athr_cfg <= cfg_data;
        REG_REL_PERCENT: rel_cfg  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- flow control
  // a stage loads when the one before holds a beat and it is empty or emptying
  always_comb begin
    take[NSTG-1] = vld[NSTG-1] & m_axis_tready;
    for (int i = NSTG - 1; i >= 1; i--) begin
      ld[i]     = vld[i-1] & (~vld[i] | take[i]);
      take[i-1] = ld[i];
    end
    s_axis_tready = ~vld[0] | take[0];
    ld[0]         = s_axis_tvalid & s_axis_tready;
    vld_next      = ld | (vld & ~take);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (ld[0]) begin
      ptr <= (ptr >= LAST_CH) ? 2'd0 : ptr + 2'd1;
    end
  end

  // ---------------------------------------------------- stage 1: capture
  always_comb begin
    item_in.ch    = ptr;
    item_in.ready = s_axis_tdata[0];
    item_in.now   = s_axis_tdata[32:1];
    item_in.cur   = s_axis_tdata[47:33];
    item_in.mode  = mode_cfg[ptr];
    item_in.kind  = kind_cfg[ptr];
    item_in.lo    = lo_cfg[ptr];
    item_in.hi    = hi_cfg[ptr];
    item_in.cyc_s = cyc_cfg[ptr];
    item_in.athr  = athr_cfg[ptr];
    item_in.rel   = rel_cfg[ptr];
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      stg_item[0] <= item_in;
    end
    for (int k = 1; k < STG_OUT; k++) begin
      if (ld[k]) begin
        stg_item[k] <= stg_item[k-1];
      end
    end
  end

  // ---------------------------------------------- stage 2: span product
  always_comb begin
    dx_c = {stg_item[0].hi[15], stg_item[0].hi} - {stg_item[0].lo[15], stg_item[0].lo};
    if (stg_item[0].mode == MODE_4_20) begin
      cm_c = $signed({2'b00, stg_item[0].cur}) - $signed(LOW_END_UA);
    end else begin
      cm_c = $signed({2'b00, stg_item[0].cur});
    end
    prod_c   = cm_c * dx_c;
    c10_full = 36'({1'b0, stg_item[0].cur} + 16'd5) * 36'(RECIP10);
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      s2_prod <= prod_c[31:0];
      s2_c10  <= c10_full[31:20];
    end
  end

  // ---------------------------- stage 3: divide by 160 or 200, round away
  always_comb begin
    amag    = s2_prod[31] ? 32'(-s2_prod) : 32'(s2_prod);
    sum1    = amag + 32'd80;
    sum2    = amag + 32'd100;
    q1_full = 55'(sum1[31:5]) * 55'(RECIP5);
    q2_full = 59'(sum2[31:3]) * 59'(RECIP25);
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      s3_qmag <= (stg_item[1].mode == MODE_0_20) ? q2_full[57:34] : q1_full[53:30];
      s3_neg  <= s2_prod[31];
      s3_c10  <= s2_c10;
    end
  end

  // ------------------------------------------------ stage 4: sample value
  always_comb begin
    lo25   = {{(VAL_W-16){stg_item[2].lo[15]}}, stg_item[2].lo};
    base_c = (lo25 <<< 6) + (lo25 <<< 5) + (lo25 <<< 2);
    qs_c   = s3_neg ? -$signed({1'b0, s3_qmag}) : $signed({1'b0, s3_qmag});
    if (stg_item[2].kind == KIND_CURRENT || stg_item[2].kind == KIND_PERCENT) begin
      v_c = $signed({{(VAL_W-12){1'b0}}, s3_c10});
    end else if (stg_item[2].mode == MODE_4_20 || stg_item[2].mode == MODE_0_20) begin
      v_c = base_c + qs_c;
    end else begin
      v_c = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      s4_v <= v_c;
    end
  end

  // ------------------------- stage 5: relative product and percent byte
  always_comb begin
    if (stg_item[3].kind == KIND_HUMIDITY || stg_item[3].kind == KIND_PERCENT) begin
      relv = REL_FIXED;
    end else begin
      relv = stg_item[3].rel;
    end
    relok_c = (relv != 8'd0) && (s4_v > $signed(REL_MIN_VALUE));
    x_c     = {8'b0, s4_v[23:0]} * {24'b0, relv};
    // value * 255 + 5000, then divide by 10000 as >> 4 and / 625
    y_c     = {s4_v[13:0], 8'b0} - {8'b0, s4_v[13:0]} + 22'd5000;
    pb_full = 37'(y_c[21:4]) * 37'(RECIP625_S);
    if (s4_v[VAL_W-1]) begin
      pb_c = 8'd0;
    end else if (s4_v > $signed(PCT_SAT_VALUE)) begin
      pb_c = 8'd255;
    end else begin
      pb_c = pb_full[35:28];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      s5_v     <= s4_v;
      s5_x     <= x_c;
      s5_relok <= relok_c;
      s5_pb    <= pb_c;
    end
  end

  // --------------------- stage 6: relative limit and scaled thresholds
  // rounded |d|/100 * 10000 >= X  <=>  |d| >= 100 * ceil(X / 10000) - 50
  always_comb begin
    xs_c   = {1'b0, s5_x} + 33'd9999;
    t_full = 58'(xs_c[32:4]) * 58'(RECIP625);
    t_c    = t_full[56:38];
  end

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      s6_v     <= s5_v;
      s6_relok <= s5_relok;
      s6_pb    <= s5_pb;
      s6_tmin  <= {1'b0, t_c, 6'b0} + {2'b0, t_c, 5'b0} + {5'b0, t_c, 2'b0} - 26'd50;
      s6_athr  <= {1'b0, stg_item[4].athr, 6'b0} + {2'b0, stg_item[4].athr, 5'b0}
                + {5'b0, stg_item[4].athr, 2'b0};
      s6_cyc   <= {stg_item[4].cyc_s, 10'b0} - {6'b0, stg_item[4].cyc_s, 4'b0}
                - {7'b0, stg_item[4].cyc_s, 3'b0};
    end
  end

  // ---------------------------------- last stage: per-channel decision
  always_comb begin
    fin_ch     = stg_item[5].ch;
    diff       = {{3{s6_v[VAL_W-1]}}, s6_v}
               - {{3{last_sent_value[fin_ch][VAL_W-1]}}, last_sent_value[fin_ch]};
    athr28     = $signed({5'b0, s6_athr});
    tmin28     = $signed({2'b0, s6_tmin});
    abs_hit    = (stg_item[5].athr != 16'd0) && (diff >= athr28 || diff <= -athr28);
    rel_hit    = s6_relok && (diff >= tmin28 || diff <= -tmin28);
    active     = (stg_item[5].mode != MODE_OFF) && stg_item[5].ready;
    cyc_hit    = (s6_cyc != 26'd0)
              && ((stg_item[5].now - last_send_ms[fin_ch]) >= {6'b0, s6_cyc});
    fin_sample = active && ((stg_item[5].now - last_process_ms[fin_ch]) >= PERIOD32);
    fin_sent   = active && (cyc_hit || (fin_sample && (abs_hit || rel_hit)));
    val_new    = fin_sample ? s6_v : last_computed_value[fin_ch];
    pb_cur     = fin_sample ? s6_pb : last_percent[fin_ch];
    fin_pct    = stg_item[5].kind == KIND_PERCENT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < MAX_CH; c++) begin
        last_process_ms[c]     <= '0;
        last_send_ms[c]        <= '0;
        last_sent_value[c]     <= '0;
        last_computed_value[c] <= '0;
        last_percent[c]        <= '0;
      end
    end else if (ld[STG_OUT]) begin
      if (fin_sample) begin
        last_computed_value[fin_ch] <= s6_v;
        last_process_ms[fin_ch]     <= stg_item[5].now;
        last_percent[fin_ch]        <= s6_pb;
      end
      if (fin_sent) begin
        last_sent_value[fin_ch] <= val_new;
        last_send_ms[fin_ch]    <= stg_item[5].now;
      end
    end
  end

  // ------------------------------------------------------ output register
  always_ff @(posedge clk) begin
    if (ld[STG_OUT]) begin
      out_ch   <= fin_ch;
      out_sent <= fin_sent;
      out_val  <= val_new;
      out_pb   <= fin_pct ? pb_cur : 8'd0;
      out_pct  <= fin_pct;
    end
  end

  assign m_axis_tvalid   = vld[STG_OUT];
  assign m_axis_tdata    = {2'b00, out_pb, {{2{out_val[VAL_W-1]}}, out_val}, out_sent, out_ch};
  assign m_axis_tuser[0] = out_pct;

  // ------------------------------------------------------------ checks
  `ASSERT_ALWAYS(a_ptr_range, clk, rst, ptr <= LAST_CH)
  `ASSERT_NEXT(a_sent_tracks, clk, rst, ld[STG_OUT] && fin_sent, last_sent_value[out_ch] == out_val)
  `ASSERT_NEXT(a_sample_kept, clk, rst, ld[STG_OUT] && fin_sample, last_computed_value[out_ch] == out_val)
  `ASSERT_IMPLIES(a_pct_only, clk, rst, m_axis_tvalid && out_pb != 8'd0, out_pct)

endmodule
